### rtl/frdwm_pkg.sv
// Shared constants, codes and control types for the convolution reverb block.
`timescale 1ns / 1ps

package frdwm_pkg;

    localparam int MAX_TAPS    = 1024;
    localparam int ADDR_W      = $clog2(MAX_TAPS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = SAMPLE_W - 1;
    localparam int OPND_W      = SAMPLE_W + 1;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int ACC_W       = 2 * SAMPLE_W + ADDR_W;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [1:0] OP_LOAD_TAP = 2'd0;
    localparam logic [1:0] OP_PROCESS  = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX   = 1'b1;

    // operand source of one multiply-accumulate beat
    localparam logic [1:0] SRC_TAP = 2'd0;
    localparam logic [1:0] SRC_DRY = 2'd1;
    localparam logic [1:0] SRC_WET = 2'd2;

    typedef struct packed {
        logic       tap_we;
        logic       hist_clr;
        logic       load_dry;
        logic       hist_we;
        logic       issue;
        logic [1:0] src;
        logic       take_wet;
        logic       take_out;
    } cmd_t;

    typedef struct packed {
        logic tap_last;
        logic pipe_busy;
        logic out_free;
    } stat_t;

endpackage

### rtl/frdwm_ctrl.sv
// Sequencer for tap loads, delay line clears and the per-sample MAC walk.
`timescale 1ns / 1ps

module frdwm_ctrl
    import frdwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  stat_t      stat,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WRITE  = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_MIXD   = 3'd4;
    localparam logic [2:0] ST_MIXW   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = SRC_TAP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (operation == OP_LOAD_TAP)
                    begin
                        cmd.tap_we = 1'b1;
                    end
                    else if (operation == OP_CLEAR)
                    begin
                        cmd.hist_clr = 1'b1;
                    end
                    else if (operation == OP_PROCESS)
                    begin
                        cmd.load_dry = 1'b1;
                        state_next   = ST_WRITE;
                    end
                    else
                    begin
                        cmd.tap_we = 1'b0;
                    end
                end
            end
            ST_WRITE:
            begin
                cmd.hist_we = 1'b1;
                state_next  = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                cmd.src   = SRC_TAP;
                if (stat.tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.take_wet = 1'b1;
                    state_next   = ST_MIXD;
                end
            end
            ST_MIXD:
            begin
                cmd.issue  = 1'b1;
                cmd.src    = SRC_DRY;
                state_next = ST_MIXW;
            end
            ST_MIXW:
            begin
                cmd.issue  = 1'b1;
                cmd.src    = SRC_WET;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold the finished sample until the output register frees up
                if (!stat.pipe_busy && stat.out_free)
                begin
                    cmd.take_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/frdwm_dp.sv
// Datapath: tap and history memories, shared MAC, rounding, mix and output register.
`timescale 1ns / 1ps

module frdwm_dp
    import frdwm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_addr,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic [ADDR_W-1:0]          tap_index,
    input  logic signed [SAMPLE_W-1:0] data_value,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       saturated
);

    localparam int RND_W = ACC_W - FRAC_W;
    localparam logic signed [RND_W-1:0] S_MAX = RND_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] S_MIN = RND_W'(-(1 << (SAMPLE_W - 1)));
    localparam logic [ACC_W-1:0]        HALF  = ACC_W'(1) << (FRAC_W - 1);
    localparam logic [SAMPLE_W-1:0]     UNITY = SAMPLE_W'(1) << FRAC_W;
    localparam logic [CNT_W-1:0]        TAPS  = CNT_W'(MAX_TAPS);

    // round half up, drop the fraction, clip; top bit is the clip flag
    function automatic logic [SAMPLE_W:0] round_clip(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0]        t;
        logic signed [RND_W-1:0] s;
        logic [SAMPLE_W:0]       r;
        t = v + HALF;
        s = t[ACC_W-1:FRAC_W];
        if (s > S_MAX)
        begin
            r = {1'b1, S_MAX[SAMPLE_W-1:0]};
        end
        else if (s < S_MIN)
        begin
            r = {1'b1, S_MIN[SAMPLE_W-1:0]};
        end
        else
        begin
            r = {1'b0, s[SAMPLE_W-1:0]};
        end
        return r;
    endfunction

    logic [SAMPLE_W-1:0] tap_mem  [MAX_TAPS];
    logic [SAMPLE_W-1:0] hist_mem [MAX_TAPS];

    logic [CNT_W-1:0]           tap_count_reg;
    logic [SAMPLE_W-1:0]        wet_mix_reg;
    logic [ADDR_W-1:0]          wp_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic [ADDR_W-1:0]          j_reg;
    logic signed [SAMPLE_W-1:0] dry_reg;
    logic signed [SAMPLE_W-1:0] wet_reg;
    logic                       flag_reg;

    logic                       s1_vld_reg;
    logic [1:0]                 s1_src_reg;
    logic                       s1_ok_reg;
    logic [SAMPLE_W-1:0]        tap_rd_reg;
    logic [SAMPLE_W-1:0]        hist_rd_reg;
    logic                       s2_vld_reg;
    logic signed [PROD_W-1:0]   mul_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       sat_out_reg;

    logic [CNT_W-1:0]           n_clamp;
    logic [CNT_W-1:0]           n_m1;
    logic [SAMPLE_W-1:0]        m_clamp;
    logic [SAMPLE_W-1:0]        dry_coef;
    logic signed [OPND_W-1:0]   op_a;
    logic signed [OPND_W-1:0]   op_b;
    logic [ADDR_W-1:0]          hist_addr;
    logic [SAMPLE_W:0]          wet_rc;
    logic [SAMPLE_W:0]          mix_rc;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            n_clamp = CNT_W'(1);
        end
        else if (tap_count_reg > TAPS)
        begin
            n_clamp = TAPS;
        end
        else
        begin
            n_clamp = tap_count_reg;
        end
    end

    assign n_m1      = n_clamp - CNT_W'(1);
    assign m_clamp   = (wet_mix_reg > UNITY) ? UNITY : wet_mix_reg;
    assign dry_coef  = UNITY - m_clamp;
    assign hist_addr = wp_reg - j_reg;
    assign wet_rc    = round_clip(acc_reg);
    assign mix_rc    = round_clip(acc_reg);

    assign stat.tap_last  = ({1'b0, j_reg} == n_m1);
    assign stat.pipe_busy = s1_vld_reg || s2_vld_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (s1_src_reg)
            SRC_DRY:
            begin
                op_a = OPND_W'(dry_reg);
                op_b = signed'({1'b0, dry_coef});
            end
            SRC_WET:
            begin
                op_a = OPND_W'(wet_reg);
                op_b = signed'({1'b0, m_clamp});
            end
            default:
            begin
                op_a = OPND_W'(signed'(tap_rd_reg));
                // entries not written since the last clear read as zero
                op_b = s1_ok_reg ? OPND_W'(signed'(hist_rd_reg)) : '0;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.tap_we)
        begin
            tap_mem[tap_index] <= data_value;
        end
        if (cmd.hist_we)
        begin
            hist_mem[wp_reg] <= dry_reg;
        end
        tap_rd_reg  <= tap_mem[j_reg];
        hist_rd_reg <= hist_mem[hist_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_dry)
        begin
            dry_reg <= data_value;
        end
        s1_src_reg <= cmd.src;
        s1_ok_reg  <= ({1'b0, j_reg} < fill_reg);
        mul_reg    <= op_a * op_b;
        if (cmd.take_wet)
        begin
            wet_reg <= wet_rc[SAMPLE_W-1:0];
        end
        if (cmd.take_out)
        begin
            sample_out_reg <= mix_rc[SAMPLE_W-1:0];
            sat_out_reg    <= mix_rc[SAMPLE_W] || flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= CNT_W'(1);
            wet_mix_reg   <= UNITY;
            wp_reg        <= '0;
            fill_reg      <= '0;
            j_reg         <= '0;
            flag_reg      <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_TAP_COUNT)
                begin
                    tap_count_reg <= cfg_wdata[CNT_W-1:0];
                end
                else
                begin
                    wet_mix_reg <= cfg_wdata;
                end
            end

            if (cmd.hist_clr)
            begin
                wp_reg   <= '0;
                fill_reg <= '0;
            end
            else if (cmd.hist_we)
            begin
                if (fill_reg != TAPS)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            else if (cmd.take_out)
            begin
                wp_reg <= wp_reg + ADDR_W'(1);
            end

            if (cmd.hist_we)
            begin
                j_reg <= '0;
            end
            else if (cmd.issue && (cmd.src == SRC_TAP))
            begin
                j_reg <= j_reg + ADDR_W'(1);
            end

            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;

            if (cmd.hist_we || cmd.take_wet)
            begin
                acc_reg <= '0;
            end
            else if (s2_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(mul_reg);
            end

            if (cmd.take_wet)
            begin
                flag_reg <= wet_rc[SAMPLE_W];
            end

            // advance the output register: load a new beat or drop a taken one
            if (cmd.take_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = sat_out_reg;

endmodule

### rtl/fir_reverb_dry_wet_mix.sv
// Top level of the convolution reverb with dry/wet mix.
//
// Input channel (in_valid/in_ready) carries one beat per command: operation
// selects load tap (data_value written to tap_index), process one dry sample,
// or clear the delay line. Only a processed sample yields an output beat on
// the out_valid/out_ready channel: sample_out plus the saturated flag.
// A processed sample reaches the output register in steps: the delay line is
// written, then the shared multiply-accumulate walks the tap and history
// memories at one tap per cycle, its pipeline registers drain, the dry and
// wet mix products are issued on the same unit and it drains again. in_ready
// rises at the edge that loads the output register, so no command is taken
// while a sample is in progress. The output register holds a finished beat
// while the receiver stalls; the block keeps accepting loads and clears, and
// a following sample waits in its last step until that register is free.
// Reset sets tap_count to 1, wet_mix to fully wet and empties the delay line
// at once (a fill count masks stale history); the tap store is undefined
// until loaded. Configuration writes go in on cfg_we; the user must make them
// only while the block is idle, as the block itself does not enforce it.
`timescale 1ns / 1ps

module fir_reverb_dry_wet_mix
    import frdwm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_addr,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 operation,
    input  logic [ADDR_W-1:0]          tap_index,
    input  logic signed [SAMPLE_W-1:0] data_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       saturated
);

    cmd_t  cmd;
    stat_t stat;

    frdwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    frdwm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .tap_index  (tap_index),
        .data_value (data_value),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

endmodule

### tb/sv/reverb_checker.sv
// Checker for the convolution reverb: predicts each mixed sample and compares output beats.
`timescale 1ns / 1ps

module reverb_checker
    import frdwm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_addr,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [1:0]                 operation,
    input  logic [ADDR_W-1:0]          tap_index,
    input  logic signed [SAMPLE_W-1:0] data_value,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] sample_out,
    input  logic                       saturated,
    output int unsigned                pending,
    output int unsigned                fail_count
);

    localparam longint Q_UNITY = longint'(1) <<< FRAC_W;
    localparam longint Q_HALF  = Q_UNITY >>> 1;
    localparam longint Q_MAX   = Q_UNITY - 1;
    localparam longint Q_MIN   = -Q_UNITY;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sat;
    } mix_result_t;

    logic signed [SAMPLE_W-1:0] taps [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
    logic [ADDR_W-1:0]          wr_ptr;
    logic [CNT_W-1:0]           tap_count_reg;
    logic [CFG_W-1:0]           wet_mix_reg;
    mix_result_t                mixed_samples_q [$];
    mix_result_t                want;
    int unsigned                errors = 0;

    // round to nearest, ties up: add half, then floor
    function automatic longint round_q15(input longint v);
        return (v + Q_HALF) >>> FRAC_W;
    endfunction

    function automatic longint clip_q15(input longint v, inout bit hit);
        if (v > Q_MAX)
        begin
            hit = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            hit = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // history must already hold the new dry sample at wr_ptr
    function automatic mix_result_t reverb_output(input logic signed [SAMPLE_W-1:0] dry);
        longint      acc;
        longint      wet;
        longint      blend;
        longint      share;
        int          n;
        int          idx;
        bit          clipped;
        mix_result_t r;
        acc = 0;
        clipped = 1'b0;
        n = int'(tap_count_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_TAPS)
            n = MAX_TAPS;
        for (int j = 0; j < n; j++)
        begin
            idx = (int'(wr_ptr) - j + MAX_TAPS) % MAX_TAPS;
            acc += longint'(taps[j]) * longint'(history[idx]);
        end
        wet = clip_q15(round_q15(acc), clipped);
        share = longint'(wet_mix_reg);
        if (share > Q_UNITY)
            share = Q_UNITY;
        blend = longint'(dry) * (Q_UNITY - share) + wet * share;
        r.sample = SAMPLE_W'(clip_q15(round_q15(blend), clipped));
        r.sat = clipped;
        return r;
    endfunction

    function automatic void note_failure(input string what);
        errors++;
        if (errors <= 10)
            $display("%0t ns: %s", $time, what);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg = CNT_W'(1);
            wet_mix_reg = CFG_W'(Q_UNITY);
            wr_ptr = '0;
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                taps[i] = '0;
                history[i] = '0;
            end
            mixed_samples_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (mixed_samples_q.size() == 0)
                    note_failure($sformatf("output beat with nothing pending: sample %0d sat %0b",
                                           sample_out, saturated));
                else
                begin
                    want = mixed_samples_q.pop_front();
                    if (sample_out !== want.sample || saturated !== want.sat)
                        note_failure($sformatf("mismatch: sample exp %0d got %0d, sat exp %0b got %0b",
                                               want.sample, sample_out, want.sat, saturated));
                end
            end

            if (cfg_we)
            begin
                if (cfg_addr == REG_TAP_COUNT)
                    tap_count_reg = cfg_wdata[CNT_W-1:0];
                else if (cfg_addr == REG_WET_MIX)
                    wet_mix_reg = cfg_wdata;
            end

            if (in_valid && in_ready)
            begin
                case (operation)
                    OP_LOAD_TAP:
                        taps[tap_index] = data_value;
                    OP_CLEAR:
                    begin
                        for (int i = 0; i < MAX_TAPS; i++)
                            history[i] = '0;
                        wr_ptr = '0;
                    end
                    OP_PROCESS:
                    begin
                        history[wr_ptr] = data_value;
                        mixed_samples_q.push_back(reverb_output(data_value));
                        wr_ptr = wr_ptr + 1'b1;
                    end
                    default:
                        ;
                endcase
            end
        end
        pending <= mixed_samples_q.size();
        fail_count <= errors;
    end

endmodule

### tb/sv/tb_top.sv
// Top of the reverb testbench: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module tb_top;
    import frdwm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_addr = '0;
    logic [CFG_W-1:0]           cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic [1:0]                 operation = '0;
    logic [ADDR_W-1:0]          tap_index = '0;
    logic signed [SAMPLE_W-1:0] data_value = '0;
    logic                       out_ready = 1'b0;
    logic                       in_ready;
    logic                       out_valid;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;

    int unsigned pending;
    int unsigned fail_count;
    int unsigned cycle_count = 0;
    int          stall_left = 0;
    int          tap_count_now = 1;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    bit          quiet = 1'b0;
    bit          tap_loaded [MAX_TAPS];

    fir_reverb_dry_wet_mix uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .tap_index  (tap_index),
        .data_value (data_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

    reverb_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .tap_index  (tap_index),
        .data_value (data_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .saturated  (saturated),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: when stalls are on, drop out_ready in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // call at a rising edge; returns at the edge that accepts the beat, valid still high
    task automatic send_cmd(input logic [1:0] op, input logic [ADDR_W-1:0] idx,
                            input logic signed [SAMPLE_W-1:0] val);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        tap_index <= idx;
        data_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (op == OP_LOAD_TAP)
            tap_loaded[idx] = 1'b1;
    endtask

    // drop valid, wait out every pending sample, then let trailing work finish
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (tap_count_now + 16) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [CFG_W-1:0] count_word,
                               input logic [CFG_W-1:0] mix_word);
        int eff;
        eff = int'(count_word[CNT_W-1:0]);
        if (eff < 1)
            eff = 1;
        if (eff > MAX_TAPS)
            eff = MAX_TAPS;
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= REG_TAP_COUNT;
        cfg_wdata <= count_word;
        @(posedge clk);
        cfg_addr <= REG_WET_MIX;
        cfg_wdata <= mix_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        tap_count_now = eff;
        // every tap in use must hold a value before a sample is processed
        for (int i = 0; i < eff; i++)
            if (!tap_loaded[i])
                send_cmd(OP_LOAD_TAP, ADDR_W'(i), pick_value());
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] count_word,
                             input logic [CFG_W-1:0] mix_word, input int items);
        int done;
        int pick;
        reconfigure(count_word, mix_word);
        gaps_on = !quiet && $urandom_range(0, 3) != 0;
        stalls_on = !quiet && $urandom_range(0, 3) != 0;
        done = 0;
        while (done < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_cmd(OP_PROCESS, ADDR_W'($urandom), pick_value());
            else if (pick < 85)
                send_cmd(OP_LOAD_TAP, ADDR_W'($urandom_range(0, MAX_TAPS - 1)), pick_value());
            else if (pick < 93)
                send_cmd(OP_CLEAR, ADDR_W'($urandom), SAMPLE_W'($urandom));
            else
                send_cmd(OP_UNUSED, ADDR_W'($urandom), SAMPLE_W'($urandom));
            if (pick < 93)
                done++;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one tap, fully wet
        send_cmd(OP_LOAD_TAP, 10'd0, 16'sh7FFF);
        send_cmd(OP_PROCESS, 10'd0, 16'sh7FFF);
        send_cmd(OP_PROCESS, 10'd0, 16'sh8000);
        send_cmd(OP_PROCESS, 10'd0, 16'sd0);
        send_cmd(OP_LOAD_TAP, 10'd0, 16'sh8000);
        send_cmd(OP_PROCESS, 10'd0, 16'sh8000);
        send_cmd(OP_PROCESS, 10'd0, 16'sh7FFF);
        send_cmd(OP_UNUSED, 10'h3FF, 16'sh1234);
        send_cmd(OP_LOAD_TAP, 10'h3FF, -16'sd1);
        send_cmd(OP_CLEAR, 10'h155, 16'sh5555);
        send_cmd(OP_PROCESS, 10'h2AA, 16'sd1);

        // zero count acts as one tap; zero mix passes the dry sample
        reconfigure(16'd0, 16'd0);
        send_cmd(OP_PROCESS, 10'd0, 16'sh7FFF);
        send_cmd(OP_PROCESS, 10'd0, 16'sh8000);

        // mix above unity acts as fully wet
        reconfigure(16'd2, 16'hFFFF);
        send_cmd(OP_LOAD_TAP, 10'd1, 16'sh7FFF);
        send_cmd(OP_PROCESS, 10'd0, 16'sh7FFF);
        send_cmd(OP_PROCESS, 10'd0, 16'sh7FFF);
        send_cmd(OP_PROCESS, 10'd0, 16'sh8000);

        reconfigure(16'd1, 16'd16384);
        send_cmd(OP_LOAD_TAP, 10'd0, 16'sh4000);
        send_cmd(OP_PROCESS, 10'd0, 16'sh7FFF);
        send_cmd(OP_PROCESS, 10'd0, -16'sd3);
        send_cmd(OP_PROCESS, 10'd0, 16'sh8000);

        run_phase(16'd3, 16'd0, 40);
        run_phase(16'd16, CFG_W'($urandom_range(0, 32768)), 60);
        // upper bits beyond the count field are dropped
        run_phase(16'hF805, 16'hFFFF, 40);
        run_phase(16'd1, 16'd16384, 50);
        run_phase(16'd2047, CFG_W'($urandom), 12);
        run_phase(16'd64, 16'd32768, 40);
        run_phase(16'd1024, CFG_W'($urandom_range(32769, 65535)), 12);
        run_phase(16'd8, CFG_W'($urandom), 60);
        run_phase(16'd0, CFG_W'($urandom), 30);
        run_phase(CFG_W'($urandom_range(2, 40)), CFG_W'($urandom_range(0, 32768)), 80);

        quiet = 1'b1;
        run_phase(CFG_W'($urandom_range(1, 24)), CFG_W'($urandom_range(0, 32768)), 80);
        run_phase(16'd32, 16'd32768, 60);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### fir_reverb_dry_wet_mix.f
rtl/frdwm_pkg.sv
rtl/frdwm_ctrl.sv
rtl/frdwm_dp.sv
rtl/fir_reverb_dry_wet_mix.sv
tb/sv/reverb_checker.sv
tb/sv/tb_top.sv
